[hw/rtl/kabf_pkg.sv]
`timescale 1ns / 1ps
// kabf_pkg: shared types, codes and fixed-point helpers of the angle/bias filter
// depends on nothing; used by every module of the block

package kabf_pkg;

   // config register indexes
   localparam logic [1:0] CSR_ANGLE_NOISE   = 2'd0;
   localparam logic [1:0] CSR_BIAS_NOISE    = 2'd1;
   localparam logic [1:0] CSR_MEASURE_NOISE = 2'd2;

   // config reset values, unsigned q7.24
   localparam logic [30:0] ANGLE_NOISE_RST   = 31'd16777;
   localparam logic [30:0] BIAS_NOISE_RST    = 31'd50332;
   localparam logic [30:0] MEASURE_NOISE_RST = 31'd503316;

   // multiply/write-back steps, in execution order
   localparam logic [3:0] OP_ANG_PRED  = 4'd0;
   localparam logic [3:0] OP_DTBB      = 4'd1;
   localparam logic [3:0] OP_CAA_LO    = 4'd2;
   localparam logic [3:0] OP_CAA_HI    = 4'd3;
   localparam logic [3:0] OP_CBB_PRED  = 4'd4;
   localparam logic [3:0] OP_SETUP     = 4'd5;
   localparam logic [3:0] OP_ANG_COR   = 4'd6;
   localparam logic [3:0] OP_BIAS_COR  = 4'd7;
   localparam logic [3:0] OP_CAA_COR   = 4'd8;
   localparam logic [3:0] OP_CAB_COR   = 4'd9;
   localparam logic [3:0] OP_CBA_COR   = 4'd10;
   localparam logic [3:0] OP_CBB_COR   = 4'd11;

   // gain selection
   localparam logic K_SEL_ANGLE = 1'b0;
   localparam logic K_SEL_BIAS  = 1'b1;

   // quotient bits of the gain division
   localparam int DIV_STEPS = 56;

   typedef struct packed {
      logic       load;
      logic       mul;
      logic       wb;
      logic [3:0] op;
      logic       div_start;
      logic       div_wb;
      logic       k_sel;
      logic       out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic out_free;
   } dp_sts_type;

   // saturate to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
      if (v > 42'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -42'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // shift right by 24, round half toward plus infinity
   function automatic logic signed [39:0] rnd24(input logic signed [63:0] v);
      logic signed [63:0] t;
      t = v + 64'sd8388608;
      return t[63:24];
   endfunction

endpackage

[hw/rtl/kabf_if.sv]
`timescale 1ns / 1ps
// kabf channel interfaces: request, response and register write channels
// depends on nothing

interface kabf_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] measured_angle;
   logic signed [31:0] measured_rate;
   logic [24:0]        step_time;
   modport source (output valid, measured_angle, measured_rate, step_time, input ready);
   modport sink (input valid, measured_angle, measured_rate, step_time, output ready);
endinterface

interface kabf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] filtered_angle;
   logic signed [31:0] unbiased_rate;
   modport source (output valid, filtered_angle, unbiased_rate, input ready);
   modport sink (input valid, filtered_angle, unbiased_rate, output ready);
endinterface

interface kabf_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/kabf_div.sv]
`timescale 1ns / 1ps
// kabf_div: restoring divider, one quotient bit per cycle
// depends on kabf_pkg

module kabf_div
   import kabf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [55:0] num,
   input  logic [31:0] den,
   output logic        busy,
   output logic        done,
   output logic [55:0] quot
);

   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  cnt_ff;
   logic [32:0] rem_ff;
   logic [55:0] num_ff;
   logic [33:0] trial;

   // trial subtract of the shifted remainder
   assign trial = {rem_ff, num_ff[55]} - {2'b00, den};

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // remainder and quotient shift
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         num_ff <= num;
      end else if (busy_ff) begin
         if (!trial[33]) begin
            rem_ff <= trial[32:0];
            num_ff <= {num_ff[54:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[31:0], num_ff[55]};
            num_ff <= {num_ff[54:0], 1'b0};
         end
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = num_ff;

endmodule

[hw/rtl/kabf_datapath.sv]
`timescale 1ns / 1ps
// kabf_datapath: filter state, config registers, shared multiplier, divider, output register
// depends on kabf_pkg and kabf_div

module kabf_datapath
   import kabf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_sts_type         sts,
   input  logic signed [31:0] measured_angle,
   input  logic signed [31:0] measured_rate,
   input  logic [24:0]        step_time,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] filtered_angle,
   output logic signed [31:0] unbiased_rate
);

   logic [30:0] angle_noise_ff, bias_noise_ff, measure_noise_ff;
   logic signed [31:0] angle_ff, bias_ff, caa_ff, cab_ff, cba_ff, cbb_ff;
   logic signed [31:0] ma_ff, mr_ff, rate_ff, y_ff, p00_ff, p01_ff, k0_ff, k1_ff;
   logic [24:0]        dt_ff;
   logic signed [35:0] inner_ff;
   logic signed [32:0] s_ff;
   logic signed [63:0] prod_ff, acc_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] fangle_ff, urate_ff;

   logic signed [32:0] mul_a, mul_b, dt_s;
   logic signed [65:0] prod_full;
   logic signed [39:0] rnd_q;
   logic signed [41:0] rnd_x;
   logic signed [63:0] caa_sum;
   logic signed [39:0] caa_rnd;
   logic signed [35:0] inner_in;
   logic signed [31:0] gain_p, gain_in;
   logic [31:0]        gain_mag;
   logic [55:0]        div_num, div_quot;
   logic [31:0]        div_den;
   logic               div_busy, div_done, s_pos, q_big;

   function automatic logic signed [41:0] ext42(input logic signed [31:0] v);
      return {{10{v[31]}}, v};
   endfunction

   assign dt_s = $signed({8'b0, dt_ff});

   // multiplier operand select
   always_comb begin
      mul_a = dt_s;
      mul_b = {rate_ff[31], rate_ff};
      unique case (cmd.op)
         OP_ANG_PRED: begin mul_a = dt_s; mul_b = {rate_ff[31], rate_ff}; end
         OP_DTBB:     begin mul_a = dt_s; mul_b = {cbb_ff[31], cbb_ff}; end
         OP_CAA_LO:   begin mul_a = dt_s; mul_b = $signed({17'b0, inner_ff[15:0]}); end
         OP_CAA_HI:   begin mul_a = dt_s; mul_b = {{13{inner_ff[35]}}, inner_ff[35:16]}; end
         OP_CBB_PRED: begin mul_a = $signed({2'b0, bias_noise_ff}); mul_b = dt_s; end
         OP_ANG_COR:  begin mul_a = {k0_ff[31], k0_ff}; mul_b = {y_ff[31], y_ff}; end
         OP_BIAS_COR: begin mul_a = {k1_ff[31], k1_ff}; mul_b = {y_ff[31], y_ff}; end
         OP_CAA_COR:  begin mul_a = {k0_ff[31], k0_ff}; mul_b = {p00_ff[31], p00_ff}; end
         OP_CAB_COR:  begin mul_a = {k0_ff[31], k0_ff}; mul_b = {p01_ff[31], p01_ff}; end
         OP_CBA_COR:  begin mul_a = {k1_ff[31], k1_ff}; mul_b = {p00_ff[31], p00_ff}; end
         OP_CBB_COR:  begin mul_a = {k1_ff[31], k1_ff}; mul_b = {p01_ff[31], p01_ff}; end
         default: ;
      endcase
   end

   assign prod_full = mul_a * mul_b;

   // product register
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= prod_full[63:0];
      end
   end

   // rounded product and write-back terms
   assign rnd_q    = rnd24(prod_ff);
   assign rnd_x    = {{2{rnd_q[39]}}, rnd_q};
   assign caa_sum  = acc_ff + (prod_ff <<< 16);
   assign caa_rnd  = rnd24(caa_sum);
   assign inner_in = $signed(rnd_q[35:0]) - {{4{cab_ff[31]}}, cab_ff}
                     - {{4{cba_ff[31]}}, cba_ff} + $signed({5'b0, angle_noise_ff});

   // gain division operands
   assign s_pos    = !s_ff[32] && (s_ff != '0);
   assign gain_p   = (cmd.k_sel == K_SEL_ANGLE) ? p00_ff : cba_ff;
   assign gain_mag = gain_p[31] ? 32'(-gain_p) : 32'(gain_p);
   assign div_den  = s_ff[31:0];
   assign div_num  = {gain_mag, 24'b0} + {25'b0, s_ff[31:1]};

   kabf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   // signed, saturated gain
   always_comb begin
      q_big = |div_quot[55:31];
      if (!s_pos) begin
         gain_in = '0;
      end else if (gain_p[31]) begin
         gain_in = q_big ? 32'sh8000_0000 : -$signed({1'b0, div_quot[30:0]});
      end else begin
         gain_in = q_big ? 32'sh7FFF_FFFF : $signed({1'b0, div_quot[30:0]});
      end
   end

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_noise_ff   <= ANGLE_NOISE_RST;
         bias_noise_ff    <= BIAS_NOISE_RST;
         measure_noise_ff <= MEASURE_NOISE_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ANGLE_NOISE:   angle_noise_ff   <= csr_data[30:0];
            CSR_BIAS_NOISE:    bias_noise_ff    <= csr_data[30:0];
            CSR_MEASURE_NOISE: measure_noise_ff <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // request operands
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ma_ff   <= measured_angle;
         mr_ff   <= measured_rate;
         dt_ff   <= step_time;
         rate_ff <= sat32(ext42(measured_rate) - ext42(bias_ff));
      end
   end

   // filter state write-back
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= '0;
         bias_ff  <= '0;
         caa_ff   <= '0;
         cab_ff   <= '0;
         cba_ff   <= '0;
         cbb_ff   <= '0;
      end else if (cmd.wb) begin
         unique case (cmd.op)
            OP_ANG_PRED: angle_ff <= sat32(ext42(angle_ff) + rnd_x);
            OP_DTBB: begin
               cab_ff <= sat32(ext42(cab_ff) - rnd_x);
               cba_ff <= sat32(ext42(cba_ff) - rnd_x);
            end
            OP_CAA_HI:   caa_ff <= sat32(ext42(caa_ff) + {{2{caa_rnd[39]}}, caa_rnd});
            OP_CBB_PRED: cbb_ff <= sat32(ext42(cbb_ff) + rnd_x);
            OP_ANG_COR:  angle_ff <= sat32(ext42(angle_ff) + rnd_x);
            OP_BIAS_COR: bias_ff <= sat32(ext42(bias_ff) + rnd_x);
            OP_CAA_COR:  caa_ff <= sat32(ext42(p00_ff) - rnd_x);
            OP_CAB_COR:  cab_ff <= sat32(ext42(p01_ff) - rnd_x);
            OP_CBA_COR:  cba_ff <= sat32(ext42(cba_ff) - rnd_x);
            OP_CBB_COR:  cbb_ff <= sat32(ext42(cbb_ff) - rnd_x);
            default: ;
         endcase
      end
   end

   // intermediate terms
   always_ff @(posedge clock) begin
      if (cmd.wb) begin
         unique case (cmd.op)
            OP_DTBB:   inner_ff <= inner_in;
            OP_CAA_LO: acc_ff <= prod_ff;
            OP_SETUP: begin
               s_ff   <= {caa_ff[31], caa_ff} + $signed({2'b0, measure_noise_ff});
               y_ff   <= sat32(ext42(ma_ff) - ext42(angle_ff));
               p00_ff <= caa_ff;
               p01_ff <= cab_ff;
            end
            default: ;
         endcase
      end
      if (cmd.div_wb) begin
         if (cmd.k_sel == K_SEL_ANGLE) begin
            k0_ff <= gain_in;
         end else begin
            k1_ff <= gain_in;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         fangle_ff <= angle_ff;
         urate_ff  <= sat32(ext42(mr_ff) - ext42(bias_ff));
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign filtered_angle = fangle_ff;
   assign unbiased_rate  = urate_ff;
   assign sts.div_done   = div_done;
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

`ifndef NO_ASSERTIONS
   // a loaded result is presented the next cycle
   a_out_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid)
      else $error("result not presented after load");

   // the divider is never restarted mid-division
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !div_busy)
      else $error("divider restarted while busy");

   // write-back consumes a product formed the cycle before
   a_wb_after_mul: assert property (@(posedge clock) disable iff (reset)
      cmd.wb |-> ($past(cmd.mul) && $past(cmd.op) == cmd.op))
      else $error("write-back without a product");
`endif

endmodule

[hw/rtl/kabf_ctrl.sv]
`timescale 1ns / 1ps
// kabf_ctrl: sequencer for predict, gain division and correction steps
// depends on kabf_pkg

module kabf_ctrl
   import kabf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_MUL      = 3'd1;
   localparam logic [2:0] S_WB       = 3'd2;
   localparam logic [2:0] S_DIV_GO   = 3'd3;
   localparam logic [2:0] S_DIV_WAIT = 3'd4;
   localparam logic [2:0] S_OUT      = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [3:0] op_ff, op_in;
   logic       ksel_ff, ksel_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      ksel_in  = ksel_ff;
      cmd      = '0;
      cmd.op   = op_ff;
      cmd.k_sel = ksel_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               op_in    = OP_ANG_PRED;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_WB;
         end
         S_WB: begin
            cmd.wb = 1'b1;
            op_in  = op_ff + 4'd1;
            if (op_ff == OP_SETUP) begin
               ksel_in  = K_SEL_ANGLE;
               state_in = S_DIV_GO;
            end else if (op_ff == OP_CBB_COR) begin
               state_in = S_OUT;
            end else begin
               state_in = S_MUL;
            end
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (sts.div_done) begin
               cmd.div_wb = 1'b1;
               if (ksel_ff == K_SEL_ANGLE) begin
                  ksel_in  = K_SEL_BIAS;
                  state_in = S_DIV_GO;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_ANG_PRED;
         ksel_ff  <= K_SEL_ANGLE;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         ksel_ff  <= ksel_in;
      end
   end

endmodule

[hw/rtl/kalman_angle_bias_filter.sv]
`timescale 1ns / 1ps
// an accepted request runs twelve multiply/write-back steps on one shared 33x33 multiplier,
// two bit-serial gain divisions and one output load before its result is presented
// a new request is taken only after the last one has been loaded into the output register
// a finished result waits in the output register while the next request is taken
// reset (synchronous, active high) zeroes angle, bias and covariance, loads noise defaults
// depends on kabf_pkg, kabf_if, kabf_div, kabf_datapath and kabf_ctrl

module kalman_angle_bias_filter
   import kabf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   kabf_req_if.sink   req_ch,
   kabf_rsp_if.source rsp_ch,
   kabf_csr_if.sink   csr_ch
);

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic       req_ready;

   // register writes are always taken
   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = req_ready;

   kabf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   kabf_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .measured_angle (req_ch.measured_angle),
      .measured_rate  (req_ch.measured_rate),
      .step_time      (req_ch.step_time),
      .csr_write      (csr_ch.valid),
      .csr_index      (csr_ch.index),
      .csr_data       (csr_ch.data),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .filtered_angle (rsp_ch.filtered_angle),
      .unbiased_rate  (rsp_ch.unbiased_rate)
   );

endmodule

[sim/kalman_angle_bias_filter_test.sv]
`timescale 1ns / 1ps
// testbench of the angle/bias kalman filter: drives requests and register writes,
// predicts each result in fixed point and checks it; depends on kabf_pkg, kabf_if and the rtl

module kalman_angle_bias_filter_test
   import kabf_pkg::*;
();

   // register index with no register behind it
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic signed [31:0] angle;
      logic signed [31:0] rate;
   } filter_out_type;

   logic clock;
   logic reset;

   kabf_req_if req_ch ();
   kabf_rsp_if rsp_ch ();
   kabf_csr_if csr_ch ();

   kalman_angle_bias_filter i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   // predictor state
   logic [30:0] q_angle_noise, q_bias_noise, q_meas_noise;
   longint est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;

   filter_out_type expected_q[$];
   int error_count = 0;
   int result_count = 0;
   int idle_pct;

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #40ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // product scaled by 2^-24, ties toward plus infinity
   function automatic longint scale_mul(input longint a, input longint b);
      longint p;
      p = a * b + 64'sd8388608;
      return p >>> 24;
   endfunction

   // gain p/s in q8.24, ties away from zero
   function automatic longint gain_of(input longint p, input longint s);
      longint mag, q;
      mag = (p < 0) ? -p : p;
      q = ((mag << 24) + s / 2) / s;
      return clamp32((p < 0) ? -q : q);
   endfunction

   function automatic filter_out_type predict_filter(input logic signed [31:0] m_angle,
                                                     input logic signed [31:0] m_rate,
                                                     input logic [24:0] dt_in);
      longint dt, rate, inner, dtbb, s, k0, k1, y, p00, p01;
      filter_out_type r;
      dt = dt_in;
      // predict
      rate = clamp32(longint'(m_rate) - est_bias);
      est_angle = clamp32(est_angle + scale_mul(dt, rate));
      inner = scale_mul(dt, p_bb) - p_ab - p_ba + longint'(q_angle_noise);
      p_aa = clamp32(p_aa + scale_mul(dt, inner));
      dtbb = scale_mul(dt, p_bb);
      p_ab = clamp32(p_ab - dtbb);
      p_ba = clamp32(p_ba - dtbb);
      p_bb = clamp32(p_bb + scale_mul(longint'(q_bias_noise), dt));
      // correct
      s = p_aa + longint'(q_meas_noise);
      k0 = 0;
      k1 = 0;
      if (s > 0) begin
         k0 = gain_of(p_aa, s);
         k1 = gain_of(p_ba, s);
      end
      y = clamp32(longint'(m_angle) - est_angle);
      est_angle = clamp32(est_angle + scale_mul(k0, y));
      est_bias = clamp32(est_bias + scale_mul(k1, y));
      p00 = p_aa;
      p01 = p_ab;
      p_aa = clamp32(p00 - scale_mul(k0, p00));
      p_ab = clamp32(p01 - scale_mul(k0, p01));
      p_ba = clamp32(p_ba - scale_mul(k1, p00));
      p_bb = clamp32(p_bb - scale_mul(k1, p01));
      r.angle = est_angle[31:0];
      r.rate = 32'(clamp32(longint'(m_rate) - est_bias));
      return r;
   endfunction

   // send one request and queue its expected result; valid stays up for a following request
   task automatic send_sample(input logic signed [31:0] m_angle, input logic signed [31:0] m_rate,
                              input logic [24:0] dt);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.measured_angle <= m_angle;
      req_ch.measured_rate <= m_rate;
      req_ch.step_time <= dt;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_q.push_back(predict_filter(m_angle, m_rate, dt));
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      if (idx == CSR_ANGLE_NOISE) q_angle_noise = value[30:0];
      else if (idx == CSR_BIAS_NOISE) q_bias_noise = value[30:0];
      else if (idx == CSR_MEASURE_NOISE) q_meas_noise = value[30:0];
      @(posedge clock);
   endtask

   // result checker with random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            result_count <= result_count + 1;
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result angle %0d rate %0d", $time,
                        rsp_ch.filtered_angle, rsp_ch.unbiased_rate);
               error_count++;
            end else begin
               if (rsp_ch.filtered_angle !== expected_q[0].angle) begin
                  $display("%0t: filtered_angle expected %0d actual %0d", $time,
                           expected_q[0].angle, rsp_ch.filtered_angle);
                  error_count++;
               end
               if (rsp_ch.unbiased_rate !== expected_q[0].rate) begin
                  $display("%0t: unbiased_rate expected %0d actual %0d", $time,
                           expected_q[0].rate, rsp_ch.unbiased_rate);
                  error_count++;
               end
               void'(expected_q.pop_front());
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   task automatic test_directed();
      send_sample(32'sd0, 32'sd0, 25'd0);
      send_sample(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 25'h1FF_FFFF);
      send_sample(32'sh8000_0000, 32'sh8000_0000, 25'h1FF_FFFF);
      send_sample(32'sh8000_0000, 32'sh7FFF_FFFF, 25'd16777216);
      send_sample(32'sh7FFF_FFFF, 32'sh8000_0000, 25'd1);
      send_sample(32'sd65536, -32'sd65536, 25'd16777);
      send_sample(-32'sd1, 32'sd1, 25'd16777216);
      send_sample(32'sd0, 32'sd0, 25'd0);
   endtask

   task automatic test_random(input int count, input int span);
      for (int i = 0; i < count; i++) begin
         if (span == 0)
            send_sample($urandom, $urandom, 25'($urandom_range(25'h1FF_FFFF)));
         else
            send_sample($urandom_range(2 * span) - span, $urandom_range(2 * span) - span,
                        25'($urandom_range(33554, 8388)));
      end
   endtask

   // noise settings at their extremes, including zero measurement noise, and a write to the unused index
   task automatic test_register_extremes();
      wait_drained();
      write_reg(CSR_ANGLE_NOISE, 32'hFFFF_FFFF);
      write_reg(CSR_BIAS_NOISE, 32'd0);
      write_reg(CSR_MEASURE_NOISE, 32'd0);
      write_reg(CSR_UNUSED, 32'h1234_5678);
      send_sample(32'sd100000, 32'sd5000, 25'd1677721);
      test_random(15, 0);
      wait_drained();
      write_reg(CSR_ANGLE_NOISE, 32'd0);
      write_reg(CSR_BIAS_NOISE, 32'h7FFF_FFFF);
      write_reg(CSR_MEASURE_NOISE, 32'h7FFF_FFFF);
      test_random(15, 0);
      wait_drained();
      write_reg(CSR_ANGLE_NOISE, 32'd16777);
      write_reg(CSR_BIAS_NOISE, 32'd50332);
      write_reg(CSR_MEASURE_NOISE, 32'd1);
      test_random(20, 1 << 20);
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.measured_angle = '0;
      req_ch.measured_rate = '0;
      req_ch.step_time = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data = '0;
      idle_pct = 19;
      q_angle_noise = ANGLE_NOISE_RST;
      q_bias_noise = BIAS_NOISE_RST;
      q_meas_noise = MEASURE_NOISE_RST;
      est_angle = 0; est_bias = 0; p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(200, 1 << 22);
      // stretch with no idling on either side
      idle_pct = 0;
      test_random(60, 0);
      idle_pct = 19;
      test_register_extremes();
      wait_drained();
      write_reg(CSR_MEASURE_NOISE, 32'd503316);
      test_random(140, 1 << 18);
      test_random(40, 0);

      wait_drained();
      $display("covered %0d results: field extremes, saturation, non-positive innovation,",
               result_count);
      $display("register extremes and random traffic with idling on both sides");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
